FILE: hw/rtl/gmcrl_pkg.sv
// Package for the grid cross run-length block: field widths, register map,
// reset values, the sequencer state type and the stored cell word layout.
// No dependencies.
`timescale 1ns / 1ps

package gmcrl_pkg;

  localparam int DIM_W  = 7;   // width of the height and width registers
  localparam int RUN_W  = 7;   // width of one run length
  localparam int OUT_W  = 7;   // width of best_cross
  localparam int APB_AW = 3;   // two 32-bit registers
  localparam int APB_DW = 32;

  localparam logic [DIM_W-1:0] DIM_RESET = 7'd64;
  localparam logic [OUT_W-1:0] OUT_MAX   = 7'd127;

  // Register index, taken from the word address bit of paddr.
  localparam logic REG_HEIGHT = 1'b0;
  localparam logic REG_WIDTH  = 1'b1;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SCAN,
    ST_FLUSH
  } state_e;

  // One stored cell: open flag, run length up to here from the left and
  // run length up to here from above.
  typedef struct packed {
    logic             open;
    logic [RUN_W-1:0] left_run;
    logic [RUN_W-1:0] up_run;
  } cell_word_t;

endpackage

FILE: hw/rtl/grid_max_cross_run_length.sv
// Top level of the grid cross run-length block: APB register port, pixel
// load, backward scan over the cell memory and the result register.
// Depends on gmcrl_pkg.
`timescale 1ns / 1ps

// Loads a frame of grid_height x grid_width pixels in raster order, one
// pixel per cycle, and then returns the largest (row run + column run - 1)
// over all open cells, saturated at 127, or 0 when nothing is open. While
// pixels load, the partial run lengths from the left and from above are
// written to a cell memory; a row buffer holds the previous row's vertical
// runs. After the last pixel, one sequencer walks the cell memory backward
// through its single read port, one cell per cycle, completing both run
// lengths and the running maximum. Each frame thus passes through the load,
// the scan and the hand-off of the result to the output register; pixels
// are not taken during the scan or the hand-off, and the hand-off also
// waits while an earlier result is still stalled in the output register.
// The memories need no clearing after reset. Writing either register
// restarts the frame.
module grid_max_cross_run_length #(
  parameter int MAX_HEIGHT = 64,
  parameter int MAX_WIDTH  = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [gmcrl_pkg::APB_AW-1:0]     paddr,
  input  logic [gmcrl_pkg::APB_DW-1:0]     pwdata,
  output logic [gmcrl_pkg::APB_DW-1:0]     prdata,
  output logic                             pready,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             cell_open_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [gmcrl_pkg::OUT_W-1:0]      best_cross_o
);
  import gmcrl_pkg::*;

  // The registers are 7 bits, so no dimension can exceed 127.
  localparam int EFF_H = (MAX_HEIGHT < 127) ? MAX_HEIGHT : 127;
  localparam int EFF_W = (MAX_WIDTH < 127) ? MAX_WIDTH : 127;
  localparam int RW    = (EFF_H > 1) ? $clog2(EFF_H) : 1;
  localparam int CW    = (EFF_W > 1) ? $clog2(EFF_W) : 1;
  localparam int CELLS = EFF_H * EFF_W;
  localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;

  localparam logic [DIM_W-1:0] EFF_H_D = DIM_W'(EFF_H);
  localparam logic [DIM_W-1:0] EFF_W_D = DIM_W'(EFF_W);

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [DIM_W-1:0] height_q, height_d;
  logic [DIM_W-1:0] width_q, width_d;
  logic             cfg_wr;
  logic             reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[APB_AW-1];
  assign cfg_wr  = psel & penable & pwrite;

  always_comb begin
    height_d = height_q;
    width_d  = width_q;
    if (cfg_wr) begin
      unique case (reg_sel)
        REG_HEIGHT: height_d = pwdata[DIM_W-1:0];
        REG_WIDTH:  width_d  = pwdata[DIM_W-1:0];
        default:    height_d = height_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_HEIGHT: prdata = {{(APB_DW-DIM_W){1'b0}}, height_q};
      REG_WIDTH:  prdata = {{(APB_DW-DIM_W){1'b0}}, width_q};
      default:    prdata = '0;
    endcase
  end

  // Clamped dimensions, minus one.
  logic [DIM_W-1:0] rows_m1_full, cols_m1_full;
  logic [RW-1:0]    rows_m1;
  logic [CW-1:0]    cols_m1;

  always_comb begin
    if (height_q == '0) begin
      rows_m1_full = '0;
    end else if (height_q > EFF_H_D) begin
      rows_m1_full = EFF_H_D - DIM_W'(1);
    end else begin
      rows_m1_full = height_q - DIM_W'(1);
    end
    if (width_q == '0) begin
      cols_m1_full = '0;
    end else if (width_q > EFF_W_D) begin
      cols_m1_full = EFF_W_D - DIM_W'(1);
    end else begin
      cols_m1_full = width_q - DIM_W'(1);
    end
  end

  assign rows_m1 = rows_m1_full[RW-1:0];
  assign cols_m1 = cols_m1_full[CW-1:0];

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  state_e state_q, state_d;

  logic pix_accept;
  logic last_pix;
  logic scan_done;
  logic out_load;
  logic out_valid_q;

  logic [RW-1:0] row_q;
  logic [CW-1:0] col_q;
  logic [AW-1:0] pix_addr_q;

  logic          a_live_q;
  logic [AW-1:0] a_addr_q;
  logic [RW-1:0] a_row_q;
  logic [CW-1:0] a_col_q;
  logic          b_valid_q;
  logic [RW-1:0] b_row_q;
  logic [CW-1:0] b_col_q;

  assign last_pix  = (row_q == rows_m1) && (col_q == cols_m1);
  assign scan_done = b_valid_q & ~a_live_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_LOAD:  if (pix_accept && last_pix) state_d = ST_SCAN;
      ST_SCAN:  if (scan_done) state_d = ST_FLUSH;
      ST_FLUSH: if (out_load) state_d = ST_LOAD;
      default:  state_d = ST_LOAD;
    endcase
  end

  always_comb begin
    in_stall_o = 1'b1;
    out_load   = 1'b0;
    unique case (state_q)
      ST_LOAD:  in_stall_o = 1'b0;
      ST_SCAN:  in_stall_o = 1'b1;
      ST_FLUSH: out_load   = ~out_valid_q | ~out_stall_i;
      default:  in_stall_o = 1'b1;
    endcase
  end

  assign pix_accept = in_valid_i & ~in_stall_o;

  // ---------------------------------------------------------------------
  // Memories
  // ---------------------------------------------------------------------
  cell_word_t       cell_mem [CELLS];
  cell_word_t       cell_rd_q;
  logic             cell_we;
  cell_word_t       cell_wdata;

  logic [RUN_W-1:0] line_buf [EFF_W];
  logic [RUN_W-1:0] lb_rd_q;
  logic             lb_we;
  logic [CW-1:0]    lb_waddr;
  logic [RUN_W-1:0] lb_wdata;
  logic [CW-1:0]    lb_raddr;

  always_ff @(posedge clk_i) begin
    if (cell_we) begin
      cell_mem[pix_addr_q] <= cell_wdata;
    end
    cell_rd_q <= cell_mem[a_addr_q];
  end

  // The row buffer is read in the cycle before the column that it serves is
  // handled; a write to that same column (one-column grids) is forwarded.
  always_ff @(posedge clk_i) begin
    if (lb_we) begin
      line_buf[lb_waddr] <= lb_wdata;
    end
    if (lb_we && (lb_waddr == lb_raddr)) begin
      lb_rd_q <= lb_wdata;
    end else begin
      lb_rd_q <= line_buf[lb_raddr];
    end
  end

  // ---------------------------------------------------------------------
  // Load datapath: runs from the left and from above
  // ---------------------------------------------------------------------
  logic [RUN_W-1:0] left_q;
  logic [RUN_W-1:0] left_in, up_in;
  logic [RUN_W-1:0] left_new, up_new;
  logic [CW-1:0]    col_next;

  assign left_in  = (col_q == '0) ? '0 : left_q;
  assign up_in    = (row_q == '0) ? '0 : lb_rd_q;
  assign left_new = cell_open_i ? left_in + RUN_W'(1) : '0;
  assign up_new   = cell_open_i ? up_in + RUN_W'(1) : '0;
  assign col_next = (col_q == cols_m1) ? '0 : col_q + CW'(1);

  assign cell_we    = pix_accept;
  assign cell_wdata = '{open: cell_open_i, left_run: left_new, up_run: up_new};

  // ---------------------------------------------------------------------
  // Scan datapath: full runs and the running maximum, last cell first
  // ---------------------------------------------------------------------
  logic [RUN_W-1:0] right_q;
  logic [RUN_W-1:0] right_in, down_in;
  logic [RUN_W-1:0] h_run, v_run;
  logic [OUT_W:0]   cross_sum;
  logic [OUT_W-1:0] cross_sat;
  logic [OUT_W-1:0] best_q;

  assign right_in = (b_col_q == cols_m1) ? '0 : right_q;
  assign down_in  = (b_row_q == rows_m1) ? '0 : lb_rd_q;

  // A blocked neighbor reads as zero, so a nonzero value means the run
  // continues and its full length is already known.
  always_comb begin
    h_run = '0;
    v_run = '0;
    if (cell_rd_q.open) begin
      h_run = (right_in != '0) ? right_in : cell_rd_q.left_run;
      v_run = (down_in != '0) ? down_in : cell_rd_q.up_run;
    end
  end

  assign cross_sum = {1'b0, h_run} + {1'b0, v_run} - (OUT_W+1)'(1);
  assign cross_sat = (cross_sum > {1'b0, OUT_MAX}) ? OUT_MAX : cross_sum[OUT_W-1:0];

  // Row buffer port sharing between load and scan.
  always_comb begin
    lb_we    = 1'b0;
    lb_waddr = col_q;
    lb_wdata = up_new;
    lb_raddr = col_q;
    unique case (state_q)
      ST_LOAD: begin
        lb_we    = pix_accept;
        lb_raddr = pix_accept ? col_next : col_q;
      end
      ST_SCAN: begin
        lb_we    = b_valid_q;
        lb_waddr = b_col_q;
        lb_wdata = v_run;
        lb_raddr = a_col_q;
      end
      ST_FLUSH: lb_we = 1'b0;
      default:  lb_we = 1'b0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------
  logic [OUT_W-1:0] best_cross_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      height_q    <= DIM_RESET;
      width_q     <= DIM_RESET;
      row_q       <= '0;
      col_q       <= '0;
      pix_addr_q  <= '0;
      a_live_q    <= 1'b0;
      b_valid_q   <= 1'b0;
      best_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      height_q <= height_d;
      width_q  <= width_d;

      if (cfg_wr) begin
        row_q      <= '0;
        col_q      <= '0;
        pix_addr_q <= '0;
      end else if (pix_accept) begin
        col_q <= col_next;
        if (last_pix) begin
          row_q      <= '0;
          pix_addr_q <= '0;
        end else begin
          pix_addr_q <= pix_addr_q + AW'(1);
          if (col_q == cols_m1) begin
            row_q <= row_q + RW'(1);
          end
        end
      end

      if (pix_accept && last_pix) begin
        a_live_q  <= 1'b1;
        b_valid_q <= 1'b0;
        best_q    <= '0;
      end else if (state_q == ST_SCAN) begin
        b_valid_q <= a_live_q;
        if (a_live_q && (a_addr_q == '0)) begin
          a_live_q <= 1'b0;
        end
        if (b_valid_q && cell_rd_q.open && (cross_sat > best_q)) begin
          best_q <= cross_sat;
        end
      end

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_accept) begin
      left_q <= left_new;
    end
    if (pix_accept && last_pix) begin
      a_addr_q <= pix_addr_q;
      a_row_q  <= rows_m1;
      a_col_q  <= cols_m1;
    end else if (state_q == ST_SCAN && a_live_q) begin
      a_addr_q <= a_addr_q - AW'(1);
      b_row_q  <= a_row_q;
      b_col_q  <= a_col_q;
      if (a_col_q == '0) begin
        a_col_q <= cols_m1;
        a_row_q <= a_row_q - RW'(1);
      end else begin
        a_col_q <= a_col_q - CW'(1);
      end
    end
    if (b_valid_q) begin
      right_q <= h_run;
    end
    if (out_load) begin
      best_cross_q <= best_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign best_cross_o = best_cross_q;

endmodule

FILE: verif/testbench.sv
// Self-checking testbench for grid_max_cross_run_length: loads random and shaped pixel
// frames over the valid/stall port, configures the grid size over APB and checks each
// best_cross result against an in-bench predictor. Depends on gmcrl_pkg and the RTL top.
`timescale 1ns / 1ps

module testbench;
  import gmcrl_pkg::*;

  localparam int GRID_MAX       = 64;
  localparam int GRID_CELLS     = GRID_MAX * GRID_MAX;
  localparam int RANDOM_ITEMS   = 1100;
  localparam int RANDOM_CELLS   = 256;
  localparam int WATCHDOG_LIMIT = 20000;

  localparam logic [APB_AW-1:0] ADDR_HEIGHT = {REG_HEIGHT, 2'b00};
  localparam logic [APB_AW-1:0] ADDR_WIDTH  = {REG_WIDTH, 2'b00};

  // Plus sign in a 3x3 grid, first pixel in the top bit.
  localparam logic [8:0] PLUS_SHAPE = 9'b010_111_010;

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;
  logic              in_valid_i;
  logic              in_stall_o;
  logic              cell_open_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [OUT_W-1:0]  best_cross_o;

  // Predictor state: the frame being loaded and the grid registers.
  logic             frame_px [GRID_CELLS];
  int               px_count;
  logic [DIM_W-1:0] height_reg;
  logic [DIM_W-1:0] width_reg;
  logic [OUT_W-1:0] expected_cross [$];

  int error_count;
  int items_sent;
  bit tx_idle;
  bit rx_idle;

  grid_max_cross_run_length u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .cell_open_i  (cell_open_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .best_cross_o (best_cross_o)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  function automatic int clamp_dim(logic [DIM_W-1:0] value);
    if (value == 0) return 1;
    if (value > GRID_MAX) return GRID_MAX;
    return int'(value);
  endfunction

  function automatic logic [OUT_W-1:0] best_cross_of(int rows, int cols);
    int h_run [GRID_CELLS];
    int v_run [GRID_CELLS];
    int run_start;
    int best;
    int sum;
    best = 0;
    for (int r = 0; r < rows; r++) begin
      run_start = 0;
      for (int c = 0; c <= cols; c++) begin
        if (c == cols || !frame_px[r*cols + c]) begin
          for (int k = run_start; k < c; k++) h_run[r*cols + k] = c - run_start;
          run_start = c + 1;
        end
      end
    end
    for (int c = 0; c < cols; c++) begin
      run_start = 0;
      for (int r = 0; r <= rows; r++) begin
        if (r == rows || !frame_px[r*cols + c]) begin
          for (int k = run_start; k < r; k++) v_run[k*cols + c] = r - run_start;
          run_start = r + 1;
        end
      end
    end
    for (int i = 0; i < rows * cols; i++) begin
      if (frame_px[i]) begin
        sum = h_run[i] + v_run[i] - 1;
        if (sum > int'(OUT_MAX)) sum = int'(OUT_MAX);
        if (sum > best) best = sum;
      end
    end
    return best[OUT_W-1:0];
  endfunction

  function automatic void take_pixel(logic open_bit);
    int rows;
    int cols;
    rows = clamp_dim(height_reg);
    cols = clamp_dim(width_reg);
    if (px_count >= rows * cols) px_count = 0;
    frame_px[px_count] = open_bit;
    px_count++;
    if (px_count == rows * cols) begin
      expected_cross.push_back(best_cross_of(rows, cols));
      px_count = 0;
    end
  endfunction

  // Valid stays high between back-to-back transactions and only drops for a gap.
  task automatic send_pixel(input logic open_bit);
    int gap;
    gap = tx_idle ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    cell_open_i <= open_bit;
    do @(negedge clk_i); while (in_stall_o);
    @(posedge clk_i);
    take_pixel(open_bit);
    items_sent++;
  endtask

  task automatic send_frame(input int pixels, input int open_pct);
    for (int i = 0; i < pixels; i++) send_pixel($urandom_range(0, 99) < open_pct);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (expected_cross.size() != 0);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [APB_AW-1:0] addr, input logic [DIM_W-1:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= APB_DW'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(negedge clk_i); while (!pready);
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (addr == ADDR_HEIGHT) height_reg = value;
    else width_reg = value;
    // Any register write restarts the frame.
    px_count = 0;
  endtask

  task automatic check_reg(input logic [APB_AW-1:0] addr, input logic [DIM_W-1:0] want);
    logic [APB_DW-1:0] got;
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(negedge clk_i); while (!pready);
    got = prdata;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got !== APB_DW'(want)) begin
      $display("%0t: register read mismatch, expected %0d, actual %0d", $time, want, got);
      error_count++;
    end
  endtask

  task automatic set_grid(input logic [DIM_W-1:0] rows, input logic [DIM_W-1:0] cols);
    write_reg(ADDR_HEIGHT, rows);
    write_reg(ADDR_WIDTH, cols);
  endtask

  function automatic logic [DIM_W-1:0] pick_dim();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return DIM_W'($urandom_range(GRID_MAX + 1, 127));
      2: return DIM_W'(GRID_MAX);
      default: return DIM_W'($urandom_range(1, 8));
    endcase
  endfunction

  function automatic int pick_density();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 100;
      2: return 25;
      3: return 50;
      4: return 75;
      default: return 90;
    endcase
  endfunction

  // Both registers read back 64 after reset; a one-column frame then runs on the
  // reset height.
  task automatic test_reset_size();
    tx_idle = 1'b0;
    rx_idle = 1'b1;
    check_reg(ADDR_HEIGHT, DIM_RESET);
    check_reg(ADDR_WIDTH, DIM_RESET);
    write_reg(ADDR_WIDTH, 1);
    send_frame(GRID_MAX, 100);
    drain_results();
  endtask

  task automatic test_single_cell();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    set_grid(1, 1);
    send_pixel(1'b0);
    send_pixel(1'b1);
    send_pixel(1'b1);
    send_pixel(1'b0);
    drain_results();
  endtask

  // A zero height or width behaves as one.
  task automatic test_zero_size();
    tx_idle = 1'b1;
    rx_idle = 1'b0;
    set_grid(0, 0);
    send_pixel(1'b1);
    send_pixel(1'b0);
    drain_results();
  endtask

  // Values above the maximum are held at 64.
  task automatic test_oversized();
    tx_idle = 1'b0;
    rx_idle = 1'b1;
    set_grid(127, 1);
    send_frame(GRID_MAX, 100);
    send_frame(GRID_MAX, 50);
    drain_results();
    set_grid(1, 100);
    send_frame(GRID_MAX, 100);
    drain_results();
  endtask

  task automatic test_shapes();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    set_grid(3, 3);
    for (int i = 0; i < 9; i++) send_pixel(PLUS_SHAPE[8-i]);
    send_frame(9, 0);
    drain_results();
  endtask

  // A register write in the middle of a frame throws away the pixels taken so far.
  task automatic test_mid_frame_write();
    tx_idle = 1'b1;
    rx_idle = 1'b0;
    set_grid(3, 4);
    send_frame(5, 100);
    drain_results();
    write_reg(ADDR_WIDTH, 4);
    send_frame(12, 50);
    send_frame(3, 0);
    drain_results();
    write_reg(ADDR_HEIGHT, 2);
    send_frame(8, 100);
    drain_results();
  endtask

  task automatic test_random_frames();
    logic [DIM_W-1:0] rows;
    logic [DIM_W-1:0] cols;
    int cells;
    int items_start;
    items_start = items_sent;
    while (items_sent - items_start < RANDOM_ITEMS) begin
      rows = pick_dim();
      cols = pick_dim();
      if (clamp_dim(rows) * clamp_dim(cols) > RANDOM_CELLS) begin
        cols = DIM_W'($urandom_range(1, 4));
      end
      cells   = clamp_dim(rows) * clamp_dim(cols);
      tx_idle = $urandom_range(0, 3) != 0;
      rx_idle = $urandom_range(0, 3) != 0;
      set_grid(rows, cols);
      repeat ($urandom_range(1, 4)) send_frame(cells, pick_density());
      // Now and then leave a frame unfinished before the next size change.
      if (cells > 1 && $urandom_range(0, 7) == 0) send_frame($urandom_range(1, cells - 1), 50);
      drain_results();
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    in_valid_i  = 1'b0;
    cell_open_i = 1'b0;
    out_stall_i = 1'b0;
    px_count    = 0;
    height_reg  = DIM_RESET;
    width_reg   = DIM_RESET;
    error_count = 0;
    items_sent  = 0;
    tx_idle     = 1'b0;
    rx_idle     = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_size();
    test_single_cell();
    test_zero_size();
    test_oversized();
    test_shapes();
    test_mid_frame_write();
    test_random_frames();

    drain_results();
    repeat (20) @(posedge clk_i);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Result side: optional stall held across the arrival of a result, then the check.
  initial begin
    int hold;
    logic [OUT_W-1:0] got;
    logic [OUT_W-1:0] want;
    wait (rst_ni);
    forever begin
      hold = rx_idle ? $urandom_range(0, 14) : 0;
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        do @(negedge clk_i); while (!out_valid_o);
        repeat (hold) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      do @(negedge clk_i); while (!out_valid_o);
      got = best_cross_o;
      if (expected_cross.size() == 0) begin
        $display("%0t: unexpected best_cross, expected none, actual %0d", $time, got);
        error_count++;
      end else begin
        want = expected_cross.pop_front();
        if (got !== want) begin
          $display("%0t: best_cross mismatch, expected %0d, actual %0d", $time, want, got);
          error_count++;
        end
      end
      @(posedge clk_i);
    end
  end

  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(negedge clk_i);
      if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("FAIL");
    $finish;
  end

endmodule

FILE: grid_max_cross_run_length.f
hw/rtl/gmcrl_pkg.sv
hw/rtl/grid_max_cross_run_length.sv
verif/testbench.sv
